@@ sv/mthd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mthd_pkg
// Shared types and constants of the median threshold hit detector.
// ---------------------------------------------------------------------------
package mthd_pkg;

    // channel set
    localparam int CHANNELS      = 10;
    localparam int CHAN_IDX_BITS = $clog2(CHANNELS);

    // register and result field widths
    localparam int GAIN_BITS      = 16;
    localparam int MASK_BITS      = 10;
    localparam int COUNT_OUT_BITS = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    // defaults handed to the top level parameters
    localparam int DEF_POWER_BITS  = 32;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_MEDIAN_RANK = 4;

    // register reset values
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(400);
    localparam logic [MASK_BITS-1:0] MASK_RESET = '0;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_GAIN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_MASK    = 1'b1;

    // per-item control flags
    typedef struct packed {
        logic lockout;
        logic clear;
    } t_item_flags;

    // one result item
    typedef struct packed {
        logic                      met;
        logic                      hit;
        logic                      pending;
        logic [CHAN_IDX_BITS-1:0]  channel;
        logic [COUNT_OUT_BITS-1:0] count;
    } t_result;

endpackage
`default_nettype wire

@@ sv/median_threshold_hit_detector.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// median_threshold_hit_detector
// Ten-channel peak detector: hit when the largest power reaches the
// median-rank power times a gain, unless locked out or masked.
// ---------------------------------------------------------------------------
// Takes one power set per clock while the input is not stalled and returns
// one result per set, in order. The four pipeline stages are the
// rank lanes (one per channel, each comparing its power with all others),
// the merge that selects the median-rank and largest power, the threshold
// multiplier, and the judge that updates the per-channel hit counters and
// the sticky pending flag. Every stage advances whenever the result
// register is empty or being taken, so the input stalls only while a
// finished result is held by a stalled output. Counters and the pending
// flag clear at reset; registers are written on the plain write port.
module median_threshold_hit_detector
    import mthd_pkg::*;
#(
    parameter int MEDIAN_RANK = DEF_MEDIAN_RANK,
    parameter int POWER_BITS  = DEF_POWER_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [POWER_BITS-1:0]     i_power_ch0,
    input  wire logic [POWER_BITS-1:0]     i_power_ch1,
    input  wire logic [POWER_BITS-1:0]     i_power_ch2,
    input  wire logic [POWER_BITS-1:0]     i_power_ch3,
    input  wire logic [POWER_BITS-1:0]     i_power_ch4,
    input  wire logic [POWER_BITS-1:0]     i_power_ch5,
    input  wire logic [POWER_BITS-1:0]     i_power_ch6,
    input  wire logic [POWER_BITS-1:0]     i_power_ch7,
    input  wire logic [POWER_BITS-1:0]     i_power_ch8,
    input  wire logic [POWER_BITS-1:0]     i_power_ch9,
    input  wire logic                      i_lockout_active,
    input  wire logic                      i_clear_pending,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_threshold_met,
    output logic                           o_hit_now,
    output logic                           o_hit_pending,
    output logic [CHAN_IDX_BITS-1:0]       o_strongest_channel,
    output logic [COUNT_OUT_BITS-1:0]      o_strongest_count
);

    logic [POWER_BITS-1:0]    w_power    [CHANNELS];
    logic [POWER_BITS-1:0]    r_s1_power [CHANNELS];
    logic [CHAN_IDX_BITS-1:0] w_rank     [CHANNELS];
    t_item_flags              w_in_flags;
    t_item_flags              r_s1_flags;
    t_item_flags              w_s2_flags;
    logic [POWER_BITS-1:0]    w_s2_med;
    logic [POWER_BITS-1:0]    w_s2_max;
    logic [CHAN_IDX_BITS-1:0] w_s2_idx;
    t_result                  w_result;

    logic                     w_advance;
    logic                     r_s1_valid;
    logic                     r_s2_valid;
    logic                     r_s3_valid;
    logic                     r_out_valid;
    logic [GAIN_BITS-1:0]     r_gain;
    logic [MASK_BITS-1:0]     r_mask;

    // gather channel ports
    assign w_power[0] = i_power_ch0;
    assign w_power[1] = i_power_ch1;
    assign w_power[2] = i_power_ch2;
    assign w_power[3] = i_power_ch3;
    assign w_power[4] = i_power_ch4;
    assign w_power[5] = i_power_ch5;
    assign w_power[6] = i_power_ch6;
    assign w_power[7] = i_power_ch7;
    assign w_power[8] = i_power_ch8;
    assign w_power[9] = i_power_ch9;

    assign w_in_flags.lockout = i_lockout_active;
    assign w_in_flags.clear   = i_clear_pending;

    // whole pipeline moves unless a held result is stalled
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD_GAIN: r_gain <= i_cfg_data[GAIN_BITS-1:0];
                REG_IGNORE_MASK:    r_mask <= i_cfg_data[MASK_BITS-1:0];
                default:            r_gain <= r_gain;
            endcase
        end
    end

    // stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // stage 1 payload beside the lane ranks
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_power <= w_power;
            r_s1_flags <= w_in_flags;
        end
    end

    // rank lanes, one per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mthd_rank_lane #(
            .POWER_BITS (POWER_BITS),
            .LANE       (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_advance),
            .i_power (w_power),
            .o_rank  (w_rank[g])
        );
    end

    // median and maximum selection
    mthd_merge #(
        .POWER_BITS  (POWER_BITS),
        .MEDIAN_RANK (MEDIAN_RANK)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_advance),
        .i_power (r_s1_power),
        .i_rank  (w_rank),
        .i_flags (r_s1_flags),
        .o_med   (w_s2_med),
        .o_max   (w_s2_max),
        .o_idx   (w_s2_idx),
        .o_flags (w_s2_flags)
    );

    // threshold, hit counters and result register
    mthd_judge #(
        .POWER_BITS (POWER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_judge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_s3_valid (r_s3_valid),
        .i_gain     (r_gain),
        .i_mask     (r_mask),
        .i_med      (w_s2_med),
        .i_max      (w_s2_max),
        .i_idx      (w_s2_idx),
        .i_flags    (w_s2_flags),
        .o_result   (w_result)
    );

    // result ports
    assign o_out_valid         = r_out_valid;
    assign o_threshold_met     = w_result.met;
    assign o_hit_now           = w_result.hit;
    assign o_hit_pending       = w_result.pending;
    assign o_strongest_channel = w_result.channel;
    assign o_strongest_count   = w_result.count;

endmodule
`default_nettype wire

@@ sv/mthd_rank_lane.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mthd_rank_lane
// One rank lane: finds the sorted position of its own channel among all
// channels, ties broken by channel index, and registers it.
// ---------------------------------------------------------------------------
module mthd_rank_lane
    import mthd_pkg::*;
#(
    parameter int POWER_BITS = DEF_POWER_BITS,
    parameter int LANE       = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [POWER_BITS-1:0]    i_power [CHANNELS],
    output logic      [CHAN_IDX_BITS-1:0] o_rank
);

    logic [CHANNELS-1:0]      w_below;
    logic [CHAN_IDX_BITS-1:0] n_rank;
    logic [CHAN_IDX_BITS-1:0] r_rank;

    // channels that sort ahead of this one: lower index wins a tie
    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            if (j < LANE) begin
                w_below[j] = (i_power[j] <= i_power[LANE]);
            end else if (j > LANE) begin
                w_below[j] = (i_power[j] < i_power[LANE]);
            end else begin
                w_below[j] = 1'b0;
            end
        end
        n_rank = CHAN_IDX_BITS'($countones(w_below));
    end

    // rank register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;

endmodule
`default_nettype wire

@@ sv/mthd_merge.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mthd_merge
// Merge stage: picks the median-rank power and the top-rank power with its
// channel index from the lane ranks.
// ---------------------------------------------------------------------------
module mthd_merge
    import mthd_pkg::*;
#(
    parameter int POWER_BITS  = DEF_POWER_BITS,
    parameter int MEDIAN_RANK = DEF_MEDIAN_RANK
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [POWER_BITS-1:0]    i_power [CHANNELS],
    input  wire logic [CHAN_IDX_BITS-1:0] i_rank  [CHANNELS],
    input  wire t_item_flags              i_flags,
    output logic      [POWER_BITS-1:0]    o_med,
    output logic      [POWER_BITS-1:0]    o_max,
    output logic      [CHAN_IDX_BITS-1:0] o_idx,
    output t_item_flags                   o_flags
);

    // rank out of range saturates to the top rank
    localparam int RANK_SEL = (MEDIAN_RANK < CHANNELS) ? MEDIAN_RANK : (CHANNELS - 1);
    localparam logic [CHAN_IDX_BITS-1:0] RANK_MED = CHAN_IDX_BITS'(RANK_SEL);
    localparam logic [CHAN_IDX_BITS-1:0] RANK_TOP = CHAN_IDX_BITS'(CHANNELS - 1);

    logic [POWER_BITS-1:0]    n_med;
    logic [POWER_BITS-1:0]    n_max;
    logic [CHAN_IDX_BITS-1:0] n_idx;
    logic [POWER_BITS-1:0]    r_med;
    logic [POWER_BITS-1:0]    r_max;
    logic [CHAN_IDX_BITS-1:0] r_idx;
    t_item_flags              r_flags;

    // ranks are unique, so each select is an or of one-hot terms
    always_comb begin
        n_med = '0;
        n_max = '0;
        n_idx = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_rank[i] == RANK_MED) begin
                n_med = n_med | i_power[i];
            end
            if (i_rank[i] == RANK_TOP) begin
                n_max = n_max | i_power[i];
                n_idx = n_idx | CHAN_IDX_BITS'(i);
            end
        end
    end

    // merge register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_med   <= n_med;
            r_max   <= n_max;
            r_idx   <= n_idx;
            r_flags <= i_flags;
        end
    end

    assign o_med   = r_med;
    assign o_max   = r_max;
    assign o_idx   = r_idx;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

@@ sv/mthd_judge.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mthd_judge
// Threshold product, hit decision, per-channel hit counters, sticky
// pending flag and the result register.
// ---------------------------------------------------------------------------
module mthd_judge
    import mthd_pkg::*;
#(
    parameter int POWER_BITS = DEF_POWER_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_s3_valid,
    input  wire logic [GAIN_BITS-1:0]     i_gain,
    input  wire logic [MASK_BITS-1:0]     i_mask,
    input  wire logic [POWER_BITS-1:0]    i_med,
    input  wire logic [POWER_BITS-1:0]    i_max,
    input  wire logic [CHAN_IDX_BITS-1:0] i_idx,
    input  wire t_item_flags              i_flags,
    output t_result                       o_result
);

    localparam int PROD_BITS = POWER_BITS + GAIN_BITS;

    logic [PROD_BITS-1:0]     w_prod;
    logic [PROD_BITS-1:0]     r_prod;
    logic [POWER_BITS-1:0]    r_max;
    logic [CHAN_IDX_BITS-1:0] r_idx;
    t_item_flags              r_flags;

    logic [COUNT_BITS-1:0]    r_count [CHANNELS];
    logic                     r_pending;
    t_result                  r_result;

    logic                     w_met;
    logic                     w_hit;
    logic                     n_pending;
    logic [COUNT_BITS-1:0]    w_old;
    logic [COUNT_BITS-1:0]    n_count;
    logic [COUNT_BITS+COUNT_OUT_BITS-1:0] w_count_ext;
    logic                     w_update;

    // full-width threshold product
    assign w_prod = PROD_BITS'(i_med) * PROD_BITS'(i_gain);

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= w_prod;
            r_max   <= i_max;
            r_idx   <= i_idx;
            r_flags <= i_flags;
        end
    end

    // hit decision; clear acts before the hit sets the flag again
    assign w_met       = (PROD_BITS'(r_max) >= r_prod);
    assign w_hit       = w_met && !r_flags.lockout && !i_mask[r_idx];
    assign n_pending   = (r_pending && !r_flags.clear) || w_hit;
    assign w_old       = r_count[r_idx];
    assign n_count     = w_hit ? (w_old + COUNT_BITS'(1)) : w_old;
    assign w_count_ext = {{COUNT_OUT_BITS{1'b0}}, n_count};
    assign w_update    = i_en && i_s3_valid;

    // hit counters and sticky flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
            end
            r_pending <= 1'b0;
        end else if (w_update) begin
            r_count[r_idx] <= n_count;
            r_pending      <= n_pending;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_result.met     <= w_met;
            r_result.hit     <= w_hit;
            r_result.pending <= n_pending;
            r_result.channel <= r_idx;
            r_result.count   <= w_count_ext[COUNT_OUT_BITS-1:0];
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

@@ sv/mthd_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mthd_checker
// Port-level checks of the median threshold hit detector, bound to the
// top level.
// ---------------------------------------------------------------------------
module mthd_checker
    import mthd_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic                     o_threshold_met,
    input wire logic                     o_hit_now,
    input wire logic                     o_hit_pending,
    input wire logic [CHAN_IDX_BITS-1:0] o_strongest_channel
);

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // input stalls only behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no held result");

    // a hit needs the threshold and sets the sticky flag
    a_hit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_now) |-> (o_threshold_met && o_hit_pending))
        else $error("hit without threshold or pending flag");

    // strongest channel is a real channel
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_strongest_channel <= CHAN_IDX_BITS'(CHANNELS - 1)))
        else $error("strongest channel out of range");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind median_threshold_hit_detector mthd_checker u_mthd_checker (.*);
`default_nettype wire
